/* design/dnt_pkg.sv */
package dnt_pkg;

	typedef struct packed {
		logic        negative;
		logic [13:0] scale;
		logic [48:0] coefficient_high;
		logic [63:0] coefficient_low;
		logic [1:0]  number_class;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  character;
		logic        character_valid;
		logic        last;
		logic [12:0] required_length;
		logic        too_small;
	} out_item_t;

	localparam logic [1:0] CLS_FINITE = 2'd0;
	localparam logic [1:0] CLS_ZERO   = 2'd1;
	localparam logic [1:0] CLS_INF    = 2'd2;
	localparam logic [1:0] CLS_NAN    = 2'd3;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_POINT = 8'h2e;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam int COEF_W   = 113;
	localparam int DIGITS   = 35;
	localparam int BCD_W    = 4 * DIGITS;
	localparam logic [12:0] LEN_LIMIT = 13'd8191;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EMIT,
		ST_LAST
	} state_t;

	// ascending sections of the text
	typedef enum logic [2:0] {
		SEC_SIGN,
		SEC_LEAD,
		SEC_DIGITS,
		SEC_TRAIL,
		SEC_NUL,
		SEC_DONE
	} sect_t;

endpackage

/* design/dnt_bcd.sv */
// shift-add-3 converter, one coefficient bit per cycle
module dnt_bcd (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [112:0]          coef,
	output logic                  done,
	output logic [4*35-1:0]       bcd
);
	import dnt_pkg::*;

	logic [COEF_W-1:0] bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [6:0]        cnt_q;
	logic              run_q;
	logic              done_q;
	logic [BCD_W-1:0]  adj;

	always_comb begin
		adj = bcd_q;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] > 4'd4) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// pulses once the last shift has landed in bcd_q
			done_q <= !load && run_q && (cnt_q == 7'(COEF_W - 1));
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(COEF_W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= coef;
			bcd_q <= '0;
		end else if (run_q) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[COEF_W-1]};
			bin_q <= {bin_q[COEF_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;
endmodule

/* design/decimal_number_to_text.sv */
// sequence: finite numbers pass through BCD conversion and then a leading-zero scan before
// characters are emitted one per cycle; other classes emit from the next cycle
// one item at a time: a new start is taken only while busy is low
// results are strobed for one cycle and cannot be stalled by the receiver
// reset: asynchronous active-low; buffer_size returns to 64, the block goes idle
module decimal_number_to_text #(
	parameter int BUFFER_MAX = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  dnt_pkg::in_item_t  in_item,
	output logic               out_strobe,
	output dnt_pkg::out_item_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [0:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import dnt_pkg::*;

	localparam int CW = $clog2(BUFFER_MAX + 1);

	logic [6:0]   bufsz_q;
	state_t       state_q, state_d;
	in_item_t     item_q;
	logic [BCD_W-1:0] dig_q;
	logic [5:0]   nd_q;
	sect_t        sec_q, sec_d;
	logic [13:0]  run_q, run_d;
	logic [5:0]   dpos_q, dpos_d;
	logic [5:0]   point_q;
	logic [12:0]  cnt_q, cnt_d;
	logic [CW-1:0] cap_q;
	logic         conv_load, conv_done;
	logic [BCD_W-1:0] bcd;
	logic [7:0]   ch;
	logic         emit_ch;
	logic [12:0]  req_len;
	logic         too;
	logic [CW-1:0] cap_w;

	assign pready = 1'b1;
	assign prdata = {25'd0, bufsz_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bufsz_q <= 7'd64;
		end else if (psel && penable && pwrite && paddr == 1'b0) begin
			bufsz_q <= pwdata[6:0];
		end
	end

	assign cap_w = (32'(bufsz_q) < BUFFER_MAX) ? CW'(bufsz_q) : CW'(BUFFER_MAX);

	dnt_bcd u_bcd (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (conv_load),
		.coef  ({item_q.coefficient_high, item_q.coefficient_low}),
		.done  (conv_done),
		.bcd   (bcd)
	);

	logic accept;
	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign conv_load = (state_q == ST_CONV) && (cnt_q == 13'd0);

	// required length from section sizes
	logic fin, neg_s;
	logic signed [13:0] sc;
	logic [13:0] len_w;
	always_comb begin
		sc    = signed'(item_q.scale);
		fin   = (item_q.number_class == CLS_FINITE) && (nd_q != 6'd0);
		neg_s = fin && item_q.negative;
		len_w = 14'd0;
		if (item_q.number_class == CLS_INF || item_q.number_class == CLS_NAN) begin
			len_w = 14'd4;
		end else if (!fin) begin
			len_w = 14'd2;
		end else if (!sc[13]) begin
			len_w = 14'(neg_s) + 14'(nd_q) + sc + 14'd1;
		end else if (-sc < 14'(nd_q)) begin
			len_w = 14'(neg_s) + 14'(nd_q) + 14'd2;
		end else begin
			len_w = 14'(neg_s) + 14'd2 + (-sc) + 14'd1;
		end
	end
	assign req_len = (len_w > 14'(LEN_LIMIT)) ? LEN_LIMIT : len_w[12:0];

	// character of current position
	logic [3:0] cur_dig;
	assign cur_dig = dig_q[BCD_W-1 -: 4];
	always_comb begin
		ch = CH_NUL;
		case (sec_q)
			SEC_SIGN:   ch = CH_MINUS;
			SEC_LEAD: begin
				if (run_q == 14'd0) ch = CH_ZERO;
				else if (run_q == 14'd1) ch = CH_POINT;
				else ch = CH_ZERO;
			end
			SEC_DIGITS: begin
				if (item_q.number_class == CLS_INF) begin
					ch = (dpos_q == 6'd0) ? CH_I : (dpos_q == 6'd1) ? CH_N : CH_F;
				end else if (item_q.number_class == CLS_NAN) begin
					ch = (dpos_q == 6'd1) ? CH_A : CH_N;
				end else if (!fin) begin
					ch = CH_ZERO;
				end else if (point_q != 6'd0 && dpos_q == point_q && run_q == 14'd1) begin
					ch = CH_POINT;
				end else begin
					ch = {4'h3, cur_dig};
				end
			end
			SEC_TRAIL:  ch = CH_ZERO;
			default:    ch = CH_NUL;
		endcase
	end

	logic [5:0] dlen;
	always_comb begin
		if (item_q.number_class == CLS_INF || item_q.number_class == CLS_NAN) dlen = 6'd3;
		else if (!fin) dlen = 6'd1;
		else dlen = nd_q;
	end

	// next section / position sequencing
	logic step_dig;
	always_comb begin
		sec_d    = sec_q;
		run_d    = run_q;
		dpos_d   = dpos_q;
		step_dig = 1'b0;
		case (sec_q)
			SEC_SIGN: begin
				if (fin && sc[13] && (-sc >= 14'(nd_q))) begin
					sec_d = SEC_LEAD; run_d = 14'd0;
				end else begin
					sec_d = SEC_DIGITS;
				end
			end
			SEC_LEAD: begin
				// run 0: '0', run 1: '.', then pad zeros until run = 1 + pad
				if (run_q == 14'd1 + (-sc) - 14'(nd_q)) begin
					sec_d = SEC_DIGITS; run_d = 14'd0;
				end else begin
					run_d = run_q + 14'd1;
				end
			end
			SEC_DIGITS: begin
				if (ch == CH_POINT && sec_q == SEC_DIGITS) begin
					run_d = 14'd0;
				end else begin
					step_dig = 1'b1;
					if (point_q != 6'd0 && dpos_q + 6'd1 == point_q) run_d = 14'd1;
					dpos_d = dpos_q + 6'd1;
					if (dpos_q + 6'd1 == dlen) begin
						if (fin && !sc[13] && sc != 14'd0) begin
							sec_d = SEC_TRAIL; run_d = 14'd1;
						end else begin
							sec_d = SEC_NUL;
						end
					end
				end
			end
			SEC_TRAIL: begin
				if (run_q == sc) sec_d = SEC_NUL;
				else run_d = run_q + 14'd1;
			end
			SEC_NUL:  sec_d = SEC_DONE;
			default:  sec_d = SEC_DONE;
		endcase
	end

	// start section for the text
	sect_t sec_init;
	always_comb begin
		if (neg_s) sec_init = SEC_SIGN;
		else if (fin && sc[13] && (-sc >= 14'(nd_q))) sec_init = SEC_LEAD;
		else sec_init = SEC_DIGITS;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) begin
				state_d = (in_item.number_class == CLS_FINITE) ? ST_CONV : ST_EMIT;
			end
			ST_CONV: if (conv_done) state_d = ST_SCAN;
			ST_SCAN: if (nd_q == 6'd0 || dig_q[BCD_W-1 -: 4] != 4'd0) state_d = ST_EMIT;
			ST_EMIT: begin
				if (cap_q == '0 || 32'(cnt_q) + 1 >= 32'(cap_q) || sec_q == SEC_NUL)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign too = 32'(len_w) > 32'(cap_q);
	logic is_last;
	assign is_last = (state_q == ST_EMIT) && (state_d == ST_IDLE);
	assign emit_ch = (state_q == ST_EMIT) && (cap_q != '0);

	always_comb begin
		out_strobe = (state_q == ST_EMIT);
		out_item.character       = emit_ch ? ch : CH_NUL;
		out_item.character_valid = emit_ch;
		out_item.last            = is_last;
		out_item.required_length = is_last ? req_len : 13'd0;
		out_item.too_small       = is_last ? too : 1'b0;
	end

	logic emit_init;
	assign emit_init = (state_q == ST_SCAN) && (state_d == ST_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sec_q   <= SEC_DIGITS;
			run_q   <= '0;
			dpos_q  <= '0;
			nd_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q  <= '0;
				nd_q   <= '0;
				sec_q  <= SEC_DIGITS;
				run_q  <= '0;
				dpos_q <= '0;
			end else if (state_q == ST_CONV) begin
				cnt_q <= 13'd1;
				if (conv_done) nd_q <= 6'(DIGITS);
			end else if (state_q == ST_SCAN) begin
				if (state_d == ST_SCAN) nd_q <= nd_q - 6'd1;
				cnt_q <= '0;
				if (emit_init) begin
					sec_q <= sec_init;
				end
			end else if (state_q == ST_EMIT) begin
				cnt_q  <= cnt_q + 13'd1;
				sec_q  <= sec_d;
				run_q  <= run_d;
				dpos_q <= dpos_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
			cap_q  <= cap_w;
		end
		if (state_q == ST_CONV && conv_done) begin
			dig_q <= bcd;
		end else if (state_q == ST_SCAN && state_d == ST_SCAN) begin
			dig_q <= {dig_q[BCD_W-5:0], 4'h0};
		end else if (state_q == ST_EMIT && step_dig && fin) begin
			dig_q <= {dig_q[BCD_W-5:0], 4'h0};
		end
		if (emit_init || (state_q == ST_IDLE)) begin
			if (fin && sc[13] && (-sc < 14'(nd_q))) point_q <= 6'(14'(nd_q) + sc);
			else point_q <= 6'd0;
		end
	end
endmodule

/* test/tb_decimal_number_to_text.sv */
`timescale 1ns / 100ps

module tb_decimal_number_to_text;
	import dnt_pkg::*;

	localparam int BUF_MAX    = 64;
	localparam int CYCLE_CAP  = 3000000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    in_item;
	logic        out_strobe;
	out_item_t   out_item;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [0:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	out_item_t   char_q[$];
	int unsigned buf_size_cfg;
	int unsigned mismatches;
	int unsigned cycles;
	bit          quiet;

	decimal_number_to_text #(.BUFFER_MAX(BUF_MAX)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.out_strobe(out_strobe), .out_item(out_item), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("[decimal_number_to_text] ERROR");
			$finish;
		end
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// expected text of one number, cut to the buffer
	task automatic predict_text(input in_item_t it);
		logic [112:0]     coef;
		byte unsigned     digs[$];
		byte unsigned     txt[$];
		int               sc, nds, cap, cnt, n, req;
		bit               too;
		out_item_t        r;
		sc = $signed(it.scale);
		cap = buf_size_cfg < BUF_MAX ? buf_size_cfg : BUF_MAX;
		coef = {it.coefficient_high, it.coefficient_low};
		case (it.number_class)
			CLS_INF: txt = '{CH_I, CH_N, CH_F, CH_NUL};
			CLS_NAN: txt = '{CH_N, CH_A, CH_N, CH_NUL};
			CLS_ZERO: txt = '{CH_ZERO, CH_NUL};
			default: begin
				while (coef != 0) begin
					digs.push_front(CH_ZERO + 8'(coef % 10));
					coef = coef / 10;
				end
				nds = digs.size();
				if (nds == 0) begin
					txt = '{CH_ZERO, CH_NUL};
				end else begin
					if (it.negative)
						txt.push_back(CH_MINUS);
					if (sc >= 0) begin
						foreach (digs[i]) txt.push_back(digs[i]);
						repeat (sc) txt.push_back(CH_ZERO);
					end else if (sc > -nds) begin
						foreach (digs[i]) begin
							txt.push_back(digs[i]);
							if (i + 1 == nds + sc)
								txt.push_back(CH_POINT);
						end
					end else begin
						txt.push_back(CH_ZERO);
						txt.push_back(CH_POINT);
						repeat (-sc - nds) txt.push_back(CH_ZERO);
						foreach (digs[i]) txt.push_back(digs[i]);
					end
					txt.push_back(CH_NUL);
				end
			end
		endcase
		cnt = txt.size();
		n = cnt < cap ? cnt : cap;
		req = cnt > int'(LEN_LIMIT) ? int'(LEN_LIMIT) : cnt;
		too = cnt > cap;
		if (n == 0) begin
			r = '{character: CH_NUL, character_valid: 1'b0, last: 1'b1,
				required_length: 13'(req), too_small: too};
			char_q.push_back(r);
		end
		for (int i = 0; i < n; i++) begin
			r.character = txt[i];
			r.character_valid = 1'b1;
			r.last = (i + 1 == n);
			r.required_length = r.last ? 13'(req) : 13'd0;
			r.too_small = r.last ? too : 1'b0;
			char_q.push_back(r);
		end
	endtask

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_strobe) begin
			if (char_q.size() == 0) begin
				report($sformatf("unexpected character %h", out_item.character));
			end else begin
				e = char_q.pop_front();
				if (out_item.character !== e.character)
					report($sformatf("character %h, want %h", out_item.character, e.character));
				if (out_item.character_valid !== e.character_valid)
					report($sformatf("character_valid %b, want %b",
						out_item.character_valid, e.character_valid));
				if (out_item.last !== e.last)
					report($sformatf("last %b, want %b", out_item.last, e.last));
				if (out_item.required_length !== e.required_length)
					report($sformatf("required_length %0d, want %0d",
						out_item.required_length, e.required_length));
				if (out_item.too_small !== e.too_small)
					report($sformatf("too_small %b, want %b", out_item.too_small, e.too_small));
			end
		end
	end

	task automatic send_item(input in_item_t it);
		int gap;
		gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (busy);
		predict_text(it);
	endtask

	// lets the block fall idle with every character received
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (busy || char_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_buffer_size(input int unsigned v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 1'b0; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		buf_size_cfg = v & 32'h7f;
		pwrite <= 1'b0; penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== buf_size_cfg)
			report($sformatf("buffer_size reads %0d, want %0d", prdata, buf_size_cfg));
		psel <= 1'b0; penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_item_t make_item(input bit neg, input int sc,
			input logic [112:0] coef, input logic [1:0] cls);
		in_item_t it;
		it.negative = neg;
		it.scale = 14'(sc);
		{it.coefficient_high, it.coefficient_low} = coef;
		it.number_class = cls;
		return it;
	endfunction

	function automatic in_item_t random_item;
		logic [112:0] coef;
		int           sc, nbits, pick;
		logic [1:0]   cls;
		coef = 113'({$urandom, $urandom, $urandom, $urandom});
		nbits = $urandom_range(0, 113);
		coef = (nbits == 113) ? coef : coef & ((113'd1 << nbits) - 1);
		pick = $urandom_range(0, 9);
		sc = (pick == 0) ? int'($urandom_range(0, 16383)) - 8192 : int'($urandom_range(0, 80)) - 40;
		pick = $urandom_range(0, 9);
		cls = pick < 7 ? CLS_FINITE : pick == 7 ? CLS_ZERO : pick == 8 ? CLS_INF : CLS_NAN;
		return make_item(1'($urandom_range(0, 1)), sc, coef, cls);
	endfunction

	task automatic test_classes;
		send_item(make_item(1'b1, 5, 113'd7, CLS_INF));
		send_item(make_item(1'b1, -3, 113'd7, CLS_NAN));
		send_item(make_item(1'b1, 4, 113'd9, CLS_ZERO));
		send_item(make_item(1'b1, 4, 113'd0, CLS_FINITE));
		send_item(make_item(1'b0, 0, {113{1'b1}}, CLS_FINITE));
		send_item(make_item(1'b1, 0, {113{1'b1}}, CLS_FINITE));
		send_item(make_item(1'b0, 0, 113'd1, CLS_FINITE));
		drain();
	endtask

	task automatic test_scales;
		send_item(make_item(1'b0, 3, 113'd42, CLS_FINITE));
		send_item(make_item(1'b1, -2, 113'd12345, CLS_FINITE));
		send_item(make_item(1'b0, -5, 113'd12345, CLS_FINITE));
		send_item(make_item(1'b1, -8, 113'd12345, CLS_FINITE));
		send_item(make_item(1'b0, -4, 113'd12345, CLS_FINITE));
		send_item(make_item(1'b0, 8191, 113'd3, CLS_FINITE));
		send_item(make_item(1'b1, -8192, 113'd3, CLS_FINITE));
		send_item(make_item(1'b0, 6111, {113{1'b1}}, CLS_FINITE));
		send_item(make_item(1'b1, -6176, 113'd5, CLS_FINITE));
		drain();
	endtask

	task automatic test_buffer_edges;
		int unsigned sizes[4] = '{0, 1, 127, 5};
		foreach (sizes[s]) begin
			set_buffer_size(sizes[s]);
			send_item(make_item(1'b1, -3, 113'd987654, CLS_FINITE));
			send_item(make_item(1'b0, 0, 113'd0, CLS_INF));
			send_item(make_item(1'b0, 0, 113'd0, CLS_ZERO));
			drain();
		end
	endtask

	task automatic test_random;
		int unsigned sizes[5] = '{64, 3, 127, 0, 20};
		for (int p = 0; p < 6; p++) begin
			set_buffer_size(p < 5 ? sizes[p] : $urandom_range(0, 127));
			quiet = (p == 5);
			repeat (17) send_item(random_item());
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 1'b0;
		pwdata = '0;
		buf_size_cfg = 64;
		mismatches = 0;
		quiet = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_classes();
		test_scales();
		test_buffer_edges();
		test_random();
		if (mismatches == 0)
			$display("[decimal_number_to_text] OK");
		else
			$display("[decimal_number_to_text] ERROR");
		$finish;
	end

endmodule
